// ----- hw/rtl/cfq_pkg.sv -----
// Shared constants, types and handshake structs of the circular FIFO queue.
package cfq_pkg;

  localparam int DEPTH   = 64;
  localparam int DATA_W  = 8;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int OFF_W   = 6;
  localparam int SUM_W   = ADDR_W + 1;
  localparam int REM_CW  = $clog2(SUM_W + 1);

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic peek_rd;
    logic resp;
  } cfq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  rem_done;
  } cfq_sts_t;

endpackage

// ----- hw/rtl/circular_fifo_queue.sv -----
// Circular FIFO queue: one word in, one result word out, with push, pop, peek and clear.
// Each word passes the execute state, a pop then a response state and a peek the
// remainder wait and a response state; the result strobe comes in the cycle after
// the last of them, and the next word is accepted then. A peek waits on the bit-serial
// remainder unit (7 steps, then a done strobe) and then on the registered store read.
// Reset (synchronous, active low) empties the queue, sets the size to 64 and makes all
// entries read as zero; results are never held off by the receiver.
module circular_fifo_queue import cfq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // Input word: accepted when start is high and busy is low.
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_func,
  input  logic [DATA_W-1:0] in_data_in,
  input  logic [OFF_W-1:0]  in_offset,
  // Queue size register; any write also empties the queue.
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  // Result word: valid for exactly one cycle.
  output logic              out_valid,
  output logic [DATA_W-1:0] out_data_out,
  output logic              out_status,
  output logic [CNT_W-1:0]  out_fill_count
);

  cfq_cmd_t cmd;
  cfq_sts_t sts;

  // The controller sequences each operation: an execute state for every word,
  // then for a pop a response state after the store read, and for a peek a wait
  // on the remainder unit before the read is issued.
  cfq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the pointers, the fill count, the entry store with its
  // per-entry written flags, and the result registers. The result registers
  // decouple the output strobe from the next accepted word.
  cfq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_func),
    .in_data_in     (in_data_in),
    .in_offset      (in_offset),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

endmodule

// ----- hw/rtl/cfq_rem.sv -----
// Bit-serial restoring remainder unit used to wrap the peek index.
module cfq_rem import cfq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [ADDR_W-1:0] rem
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REM_CW-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [ADDR_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  shifted;
  logic [CNT_W-1:0]  diff;
  logic              ge;

  // One dividend bit is brought in per cycle, most significant first.
  assign shifted = {rem_r, dvd_r[SUM_W-1]};
  assign ge      = (shifted >= divisor);
  assign diff    = shifted - divisor;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = REM_CW'(SUM_W);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[ADDR_W-1:0] : shifted[ADDR_W-1:0];
      dvd_nxt = {dvd_r[SUM_W-2:0], 1'b0};
      cnt_nxt = cnt_r - REM_CW'(1);
      if (cnt_r == REM_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- hw/rtl/cfq_dp.sv -----
// Datapath of the circular FIFO queue: pointers, fill count, entry store and result registers.
module cfq_dp import cfq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfq_cmd_t          cmd,
  output cfq_sts_t          sts,
  input  logic [1:0]        in_func,
  input  logic [DATA_W-1:0] in_data_in,
  input  logic [OFF_W-1:0]  in_offset,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_data_out,
  output logic              out_status,
  output logic [CNT_W-1:0]  out_fill_count
);

  func_t             func_r;
  logic [DATA_W-1:0] din_r;
  logic [OFF_W-1:0]  off_r;

  logic [CNT_W-1:0]  size_r, size_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [ADDR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_hit_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_status_r, out_status_nxt;
  logic [CNT_W-1:0]  out_fill_r;

  logic              full, empty;
  logic [CNT_W-1:0]  head_inc, tail_inc;
  logic [ADDR_W-1:0] head_wrap, tail_wrap;
  logic              do_push, do_pop, do_clear, load_imm, load_out;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  cfg_size;
  logic [SUM_W-1:0]  peek_sum;
  logic              rem_done;
  logic [ADDR_W-1:0] rem_q;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= func_t'(in_func);
      din_r  <= in_data_in;
      off_r  <= in_offset;
    end
  end

  assign full  = (count_r >= size_r);
  assign empty = (count_r == '0);

  assign head_inc  = {1'b0, head_r} + CNT_W'(1);
  assign tail_inc  = {1'b0, tail_r} + CNT_W'(1);
  assign head_wrap = (head_inc == size_r) ? '0 : head_inc[ADDR_W-1:0];
  assign tail_wrap = (tail_inc == size_r) ? '0 : tail_inc[ADDR_W-1:0];

  assign do_push  = cmd.exec && (func_r == FUNC_PUSH) && !full;
  assign do_pop   = cmd.exec && (func_r == FUNC_POP) && !empty;
  assign do_clear = cmd.exec && (func_r == FUNC_CLEAR);
  assign load_imm = cmd.exec && ((func_r == FUNC_PUSH) || (func_r == FUNC_CLEAR));
  assign load_out = load_imm || cmd.resp;

  assign rd_en   = do_pop || cmd.peek_rd;
  assign rd_addr = cmd.peek_rd ? rem_q : head_r;

  // A size of zero acts as one; sizes above the store depth saturate.
  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_size = CNT_W'(1);
    end else if (cfg_wr_data > CNT_W'(DEPTH)) begin
      cfg_size = CNT_W'(DEPTH);
    end else begin
      cfg_size = cfg_wr_data;
    end
  end

  always_comb begin
    size_nxt  = size_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cfg_wr_en) begin
      size_nxt  = cfg_size;
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (do_clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (do_push) begin
      tail_nxt  = tail_wrap;
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop) begin
      head_nxt  = head_wrap;
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= CNT_W'(DEPTH);
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      size_r  <= size_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // The peek index head + offset is wrapped by the remainder unit.
  assign peek_sum = {1'b0, head_r} + SUM_W'(off_r);

  cfq_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.exec && (func_r == FUNC_PEEK)),
    .dividend (peek_sum),
    .divisor  (size_r),
    .done     (rem_done),
    .rem      (rem_q)
  );

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail_r] <= din_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (cmd.exec || cmd.peek_rd) begin
      rd_hit_r <= rd_en && vld_r[rd_addr];
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (do_push) begin
      vld_r[tail_r] <= 1'b1;
    end
  end

  assign out_data_nxt   = (cmd.resp && rd_hit_r) ? rd_data_r : '0;
  assign out_status_nxt = load_imm && (func_r == FUNC_PUSH) && full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= load_out;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
      out_fill_r   <= count_nxt;
    end
  end

  assign sts.func     = func_r;
  assign sts.rem_done = rem_done;

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;

endmodule

// ----- hw/rtl/cfq_ctrl.sv -----
// Controller state machine of the circular FIFO queue.
module cfq_ctrl import cfq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  cfq_sts_t sts,
  output cfq_cmd_t cmd,
  output logic     busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        unique case (sts.func)
          FUNC_PUSH, FUNC_CLEAR: state_nxt = ST_IDLE;
          FUNC_POP:              state_nxt = ST_RESP;
          FUNC_PEEK:             state_nxt = ST_DIV;
        endcase
      end
      ST_DIV: begin
        if (sts.rem_done) begin
          cmd.peek_rd = 1'b1;
          state_nxt   = ST_RESP;
        end
      end
      ST_RESP: begin
        cmd.resp  = 1'b1;
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
